// ===== sv/tzrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-stage zero-run compressor package
// Shared types, constants and register indexes for the compressor modules.
// ----------------------------------------------------------------------------
package tzrc_pkg;

   localparam int CHAR_BITS         = 7;
   localparam int BYTE_BITS         = 8;
   localparam int CFG_BITS          = 3;
   localparam int DEF_MAX_CODE_BITS = 4;

   localparam logic [CFG_BITS-1:0] FIRST_CODE_BITS_RST  = 3'd2;
   localparam logic [CFG_BITS-1:0] SECOND_CODE_BITS_RST = 3'd3;

   // Configuration register indexes.
   typedef enum logic {
      CFG_FIRST_CODE_BITS  = 1'b0,
      CFG_SECOND_CODE_BITS = 1'b1
   } cfg_index_type;

   // Classification of an incoming item.
   typedef enum logic {
      KIND_CHAR  = 1'b0,
      KIND_FLUSH = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type        kind;
      logic [CHAR_BITS-1:0] character;
   } item_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage
`default_nettype wire

// ===== sv/tzrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compressor front end
// Accepts items, classifies them as character or flush, and queues them.
// ----------------------------------------------------------------------------
module tzrc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [tzrc_pkg::CHAR_BITS-1:0]     req_character,
   input  wire logic                               req_flush,
   output logic                                    head_valid,
   output tzrc_pkg::item_type                      head_item,
   input  wire logic                               head_pop
);
   import tzrc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   item_type          q_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              push;
   logic              pop;
   item_type          new_item;

   assign req_ready  = (count_ff != CNTW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      new_item.kind      = req_flush ? KIND_FLUSH : KIND_CHAR;
      new_item.character = req_character;
   end

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tzrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compressor back end
// Serial two-stage zero-run encoder, bit packer and output register.
// ----------------------------------------------------------------------------
module tzrc_back #(
   parameter int MAX_CODE_BITS = tzrc_pkg::DEF_MAX_CODE_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [tzrc_pkg::CFG_BITS-1:0]      first_code_bits,
   input  wire logic [tzrc_pkg::CFG_BITS-1:0]      second_code_bits,
   input  wire logic                               head_valid,
   input  wire tzrc_pkg::item_type                 head_item,
   output logic                                    head_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [tzrc_pkg::BYTE_BITS-1:0]          rsp_packed_byte,
   output logic                                    rsp_last_of_item
);
   import tzrc_pkg::*;

   localparam int CW = $clog2(MAX_CODE_BITS + 1);
   localparam int MW = MAX_CODE_BITS;
   localparam int PW = CHAR_BITS + MAX_CODE_BITS;
   localparam int TW = $clog2(PW + 1);
   localparam int BW = $clog2(CHAR_BITS + 1);
   localparam logic [CW-1:0] MAX_W = CW'(MAX_CODE_BITS);

   state_type              state_ff, state_in;
   logic [CHAR_BITS-1:0]   chr_ff, chr_in;
   logic [BW-1:0]          bits_ff, bits_in;
   logic [MW-1:0]          code1_ff, code1_in;
   logic [CW-1:0]          c1left_ff, c1left_in;
   logic [MW-1:0]          cnt1_ff, cnt1_in;
   logic [MW-1:0]          cnt2_ff, cnt2_in;
   logic [CHAR_BITS-1:0]   buf_ff, buf_in;
   logic [2:0]             fill_ff, fill_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [BYTE_BITS-1:0]   pend_byte_ff, pend_byte_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_BITS-1:0]   out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;

   logic [CW-1:0]          w1, w2;
   logic [MW-1:0]          esc1, esc2;
   logic                   out_free, adv;

   logic                   s1_bit, s1_emit;
   logic [MW:0]            s1_inc;
   logic [MW-1:0]          s1_code, s1_cnt;
   logic                   s2_bit, s2_emit;
   logic [MW:0]            s2_inc;
   logic [MW-1:0]          s2_code, s2_cnt;

   logic [CW-1:0]          pk_n;
   logic [PW-1:0]          pk_wide;
   logic [TW-1:0]          pk_total, pk_rem;
   logic                   pk_done;
   logic [BYTE_BITS-1:0]   pk_byte;
   logic [CHAR_BITS-1:0]   pk_buf;
   logic [2:0]             pk_fill;
   logic [BYTE_BITS-1:0]   flush_byte;

   function automatic logic [CW-1:0] clamp_w(input logic [CFG_BITS-1:0] v);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (int'(v) > MAX_CODE_BITS) begin
         r = MAX_W;
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   assign w1   = clamp_w(first_code_bits);
   assign w2   = clamp_w(second_code_bits);
   assign esc1 = MW'((1 << w1) - 1);
   assign esc2 = MW'((1 << w2) - 1);

   assign out_free = !out_valid_ff || rsp_ready;
   assign adv      = !pend_valid_ff || out_free;

   // Stage one: one character bit.
   always_comb begin
      s1_bit = chr_ff[CHAR_BITS-1];
      s1_inc = {1'b0, cnt1_ff} + (MW+1)'(1);
      if (s1_bit) begin
         s1_emit = 1'b1;
         s1_code = (cnt1_ff >= esc1) ? esc1 : cnt1_ff;
         s1_cnt  = '0;
      end else if (s1_inc >= {1'b0, esc1}) begin
         s1_emit = 1'b1;
         s1_code = esc1;
         s1_cnt  = '0;
      end else begin
         s1_emit = 1'b0;
         s1_code = '0;
         s1_cnt  = s1_inc[MW-1:0];
      end
   end

   // Stage two: one code bit from stage one.
   always_comb begin
      s2_bit = code1_ff[MW-1];
      s2_inc = {1'b0, cnt2_ff} + (MW+1)'(1);
      if (s2_bit) begin
         s2_emit = 1'b1;
         s2_code = (cnt2_ff >= esc2) ? esc2 : cnt2_ff;
         s2_cnt  = '0;
      end else if (s2_inc >= {1'b0, esc2}) begin
         s2_emit = 1'b1;
         s2_code = esc2;
         s2_cnt  = '0;
      end else begin
         s2_emit = 1'b0;
         s2_code = '0;
         s2_cnt  = s2_inc[MW-1:0];
      end
   end

   // Packer: append the stage-two code and cut off a byte when eight bits are in.
   always_comb begin
      pk_n     = s2_emit ? w2 : '0;
      pk_wide  = (PW'(buf_ff) << pk_n) | PW'(s2_code);
      pk_total = TW'(fill_ff) + TW'(pk_n);
      pk_done  = (pk_total >= TW'(BYTE_BITS));
      pk_rem   = pk_total - TW'(BYTE_BITS);
      pk_byte  = BYTE_BITS'(pk_wide >> pk_rem);
      if (pk_done) begin
         pk_buf  = CHAR_BITS'(pk_wide & ((PW'(1) << pk_rem) - PW'(1)));
         pk_fill = 3'(pk_rem);
      end else begin
         pk_buf  = CHAR_BITS'(pk_wide);
         pk_fill = 3'(pk_total);
      end
      flush_byte = BYTE_BITS'({1'b0, buf_ff} << (4'(BYTE_BITS) - {1'b0, fill_ff}));
   end

   always_comb begin
      state_in      = state_ff;
      chr_in        = chr_ff;
      bits_in       = bits_ff;
      code1_in      = code1_ff;
      c1left_in     = c1left_ff;
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      buf_in        = buf_ff;
      fill_in       = fill_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      head_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_item.kind == KIND_FLUSH) begin
                  if (fill_ff == '0 || out_free) begin
                     head_pop = 1'b1;
                     if (fill_ff != '0) begin
                        out_valid_in = 1'b1;
                        out_byte_in  = flush_byte;
                        out_last_in  = 1'b1;
                     end
                     buf_in  = '0;
                     fill_in = '0;
                     cnt1_in = '0;
                     cnt2_in = '0;
                  end
               end else begin
                  head_pop  = 1'b1;
                  chr_in    = head_item.character;
                  bits_in   = BW'(CHAR_BITS);
                  c1left_in = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (c1left_ff != '0) begin
                  code1_in  = code1_ff << 1;
                  c1left_in = c1left_ff - CW'(1);
                  cnt2_in   = s2_cnt;
                  buf_in    = pk_buf;
                  fill_in   = pk_fill;
                  if (pk_done) begin
                     // The held byte is not the last one; a newer byte replaces it.
                     if (pend_valid_ff) begin
                        out_valid_in = 1'b1;
                        out_byte_in  = pend_byte_ff;
                        out_last_in  = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_byte_in  = pk_byte;
                  end
               end else if (bits_ff != '0) begin
                  chr_in  = chr_ff << 1;
                  bits_in = bits_ff - BW'(1);
                  cnt1_in = s1_cnt;
                  if (s1_emit) begin
                     code1_in  = s1_code << (MAX_W - w1);
                     c1left_in = w1;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = pend_byte_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bits_ff       <= '0;
         c1left_ff     <= '0;
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         buf_ff        <= '0;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bits_ff       <= bits_in;
         c1left_ff     <= c1left_in;
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         buf_ff        <= buf_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff       <= chr_in;
      code1_ff     <= code1_in;
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_packed_byte  = out_byte_ff;
   assign rsp_last_of_item = out_last_ff;

`ifndef ASSERT_OFF
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held byte survived past the end of its item");

   a_code_left_bound: assert property (@(posedge clock) disable iff (reset)
      c1left_ff <= MAX_W)
      else $error("stage one code bit count exceeds the widest code");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (c1left_ff == '0 && bits_ff == '0))
      else $error("item finished with bits still to encode");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (head_pop && head_item.kind == KIND_FLUSH) |=>
      (fill_ff == '0 && cnt1_ff == '0 && cnt2_ff == '0))
      else $error("flush left packer or run state behind");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== sv/two_stage_zero_run_compressor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-stage zero-run compressor
// Serializes 7-bit characters through two cascaded zero-run encoders and
// packs the resulting code bits into bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    req_character[6:0], req_flush
//   rsp_      out         rsp_valid/rsp_ready    rsp_packed_byte[7:0],
//                                                rsp_last_of_item
//   csr_      in          csr_valid/csr_ready    csr_index, csr_wdata[2:0]
//
// In the back end a character item is loaded, each of its character bits
// is run through stage one, each stage-one code bit is fed to stage two,
// and the item is closed out. A flush item is handled in the idle state.
// Reset is synchronous and active high; it restores the code widths to 2 and 3
// and clears run counts, packer and queue. There is no clearing pass.
// A two-entry queue lets the front keep taking items while the back end is
// busy or stalled on rsp_ready; the back end stalls when the output register
// is full and it holds a byte or has a flushed byte to move into it.
//
module two_stage_zero_run_compressor #(
   parameter int MAX_CODE_BITS = tzrc_pkg::DEF_MAX_CODE_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input items
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [tzrc_pkg::CHAR_BITS-1:0]     req_character,
   input  wire logic                               req_flush,
   // Result items
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [tzrc_pkg::BYTE_BITS-1:0]          rsp_packed_byte,
   output logic                                    rsp_last_of_item,
   // Configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_index,
   input  wire logic [tzrc_pkg::CFG_BITS-1:0]      csr_wdata
);
   import tzrc_pkg::*;

   // Code width registers. Out-of-range values are clamped in the back end.
   logic [CFG_BITS-1:0] first_bits_ff, first_bits_in;
   logic [CFG_BITS-1:0] second_bits_ff, second_bits_in;

   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      first_bits_in  = first_bits_ff;
      second_bits_in = second_bits_ff;
      if (csr_valid) begin
         case (cfg_index_type'(csr_index))
            CFG_FIRST_CODE_BITS: begin
               first_bits_in = csr_wdata;
            end
            CFG_SECOND_CODE_BITS: begin
               second_bits_in = csr_wdata;
            end
            default: begin
               first_bits_in = first_bits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bits_ff  <= FIRST_CODE_BITS_RST;
         second_bits_ff <= SECOND_CODE_BITS_RST;
      end else begin
         first_bits_ff  <= first_bits_in;
         second_bits_ff <= second_bits_in;
      end
   end

   // The front end classifies and queues items.
   tzrc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .req_flush     (req_flush),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   // Back end: one bit per cycle unless stalled; drives the result register.
   tzrc_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .first_code_bits  (first_bits_ff),
      .second_code_bits (second_bits_ff),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule
`default_nettype wire

// ===== tb/tzrc_byte_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed byte checker
// Follows the code widths and every accepted item. Computes the bytes that
// each item must produce and compares every accepted byte with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module tzrc_byte_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [tzrc_pkg::CHAR_BITS-1:0] req_character,
   input  wire logic                           req_flush,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [tzrc_pkg::BYTE_BITS-1:0] rsp_packed_byte,
   input  wire logic                           rsp_last_of_item,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [tzrc_pkg::CFG_BITS-1:0]  csr_wdata,
   output int                                  mismatch_count,
   output int                                  bytes_pending
);
   import tzrc_pkg::*;

   typedef struct packed {
      logic [BYTE_BITS-1:0] packed_byte;
      logic                 last_of_item;
   } byte_result_type;

   byte_result_type      owed_bytes[$];
   logic [CFG_BITS-1:0]  width_one_cfg;
   logic [CFG_BITS-1:0]  width_two_cfg;
   logic [3:0]           run_one;
   logic [3:0]           run_two;
   logic [CHAR_BITS-1:0] pack_bits;
   logic [2:0]           pack_count;
   int                   new_bytes;

   initial begin
      mismatch_count = 0;
      bytes_pending  = 0;
   end

   // Register values of zero act as one bit, values above the maximum as the maximum.
   function automatic int code_width(input logic [CFG_BITS-1:0] w);
      if (w == '0) return 1;
      if (w > DEF_MAX_CODE_BITS) return DEF_MAX_CODE_BITS;
      return int'(w);
   endfunction

   function automatic void pack_code_bit(input logic b);
      byte_result_type r;
      if (pack_count == 3'd7) begin
         r.packed_byte  = {pack_bits, b};
         r.last_of_item = 1'b0;
         owed_bytes.push_back(r);
         new_bytes++;
         pack_bits  = '0;
         pack_count = '0;
      end else begin
         pack_bits  = {pack_bits[CHAR_BITS-2:0], b};
         pack_count = pack_count + 3'd1;
      end
   endfunction

   function automatic void send_code_two(input logic [3:0] code, input int w);
      int k;
      for (k = w - 1; k >= 0; k--) pack_code_bit(code[k]);
   endfunction

   function automatic void stage_two_bit(input logic b);
      int w;
      int esc;
      w   = code_width(width_two_cfg);
      esc = (1 << w) - 1;
      if (b) begin
         // A count left above a narrowed escape code goes out as the escape code.
         send_code_two((run_two >= esc) ? 4'(esc) : run_two, w);
         run_two = '0;
      end else begin
         run_two = run_two + 4'd1;
         if (run_two >= esc) begin
            send_code_two(4'(esc), w);
            run_two = '0;
         end
      end
   endfunction

   function automatic void send_code_one(input logic [3:0] code, input int w);
      int k;
      for (k = w - 1; k >= 0; k--) stage_two_bit(code[k]);
   endfunction

   function automatic void stage_one_bit(input logic b);
      int w;
      int esc;
      w   = code_width(width_one_cfg);
      esc = (1 << w) - 1;
      if (b) begin
         send_code_one((run_one >= esc) ? 4'(esc) : run_one, w);
         run_one = '0;
      end else begin
         run_one = run_one + 4'd1;
         if (run_one >= esc) begin
            send_code_one(4'(esc), w);
            run_one = '0;
         end
      end
   endfunction

   function automatic void predict_item(input logic [CHAR_BITS-1:0] ch,
                                        input item_kind_type kind);
      byte_result_type r;
      int k;
      new_bytes = 0;
      if (kind == KIND_FLUSH) begin
         // The partial byte goes out left aligned; pending zero runs are lost.
         if (pack_count != '0) begin
            r.packed_byte  = {1'b0, pack_bits} << (BYTE_BITS - int'(pack_count));
            r.last_of_item = 1'b1;
            owed_bytes.push_back(r);
         end
         pack_bits  = '0;
         pack_count = '0;
         run_one    = '0;
         run_two    = '0;
      end else begin
         for (k = CHAR_BITS - 1; k >= 0; k--) stage_one_bit(ch[k]);
         if (new_bytes > 0) begin
            r = owed_bytes.pop_back();
            r.last_of_item = 1'b1;
            owed_bytes.push_back(r);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      byte_result_type got;
      byte_result_type want;
      if (reset) begin
         width_one_cfg = FIRST_CODE_BITS_RST;
         width_two_cfg = SECOND_CODE_BITS_RST;
         run_one       = '0;
         run_two       = '0;
         pack_bits     = '0;
         pack_count    = '0;
         owed_bytes.delete();
      end else begin
         // Results are checked before the prediction of an item taken at the
         // same edge, since they can only belong to earlier items.
         if (rsp_valid && rsp_ready) begin
            got.packed_byte  = rsp_packed_byte;
            got.last_of_item = rsp_last_of_item;
            if (owed_bytes.size() == 0) begin
               $error("unexpected byte %02h with last_of_item %0b",
                      got.packed_byte, got.last_of_item);
               mismatch_count++;
            end else begin
               want = owed_bytes.pop_front();
               if (got.packed_byte !== want.packed_byte) begin
                  $error("packed_byte: expected %02h, actual %02h",
                         want.packed_byte, got.packed_byte);
                  mismatch_count++;
               end
               if (got.last_of_item !== want.last_of_item) begin
                  $error("last_of_item: expected %0b, actual %0b",
                         want.last_of_item, got.last_of_item);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (cfg_index_type'(csr_index))
               CFG_FIRST_CODE_BITS:  width_one_cfg = csr_wdata;
               CFG_SECOND_CODE_BITS: width_two_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_item(req_character, item_kind_type'(req_flush));
      end
      bytes_pending = owed_bytes.size();
   end

endmodule

// ===== tb/tb_two_stage_zero_run_compressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stage zero-run compressor testbench
// Drives characters and flushes through the compressor under several code
// width settings, with random gaps on both channels, while a checker beside
// the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module tb_two_stage_zero_run_compressor;
   import tzrc_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 12;
   // Covers a character still in the back end and the two more items that the
   // front queue holds, so this covers everything in flight.
   localparam int DRAIN_CYCLES     = 150;
   localparam int RANDOM_PER_PHASE = 16;
   localparam int PHASES           = 8;
   localparam int MAX_GAP          = 11;
   localparam int CYCLE_LIMIT      = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CHAR_BITS-1:0] req_character;
   logic                 req_flush;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_BITS-1:0] rsp_packed_byte;
   logic                 rsp_last_of_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_index;
   logic [CFG_BITS-1:0]  csr_wdata;

   int   mismatch_count;
   int   bytes_pending;
   int   cycle_count = 0;
   int   ready_hold  = 0;
   // When set, the matching side never idles for the current phase.
   logic req_burst   = 1'b0;
   logic rsp_burst   = 1'b0;

   two_stage_zero_run_compressor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .req_flush        (req_flush),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   tzrc_byte_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .req_flush        (req_flush),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .bytes_pending    (bytes_pending)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // The run is cut off if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: after every accepted byte it draws a random stall, none in
   // a burst phase. The stall also runs down while no byte is offered, so stalls
   // land on every phase of the back end's work.
   always @(posedge clock) begin : result_side
      int stall;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         rsp_ready  <= (stall == 0);
         ready_hold <= stall;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= (ready_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offers one item after a random gap. Valid is lowered only when a gap
   // follows, so back-to-back items keep it high across the edge.
   task automatic offer_item(input logic [CHAR_BITS-1:0] ch, input logic fl);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      req_flush     <= fl;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops the input and waits until every owed byte has come out, then lets
   // the back end finish any item that produces no byte at all.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (bytes_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both code widths while the block is idle, keeping valid high
   // between the two writes.
   task automatic write_widths(input logic [CFG_BITS-1:0] width_one,
                               input logic [CFG_BITS-1:0] width_two);
      csr_valid <= 1'b1;
      csr_index <= CFG_FIRST_CODE_BITS;
      csr_wdata <= width_one;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CFG_SECOND_CODE_BITS;
      csr_wdata <= width_two;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Characters come in four flavors: uniform, sparse (long zero runs that
   // hit the escape codes), dense, and a single set bit.
   function automatic logic [CHAR_BITS-1:0] random_char();
      logic [CHAR_BITS-1:0] a;
      logic [CHAR_BITS-1:0] b;
      logic [CHAR_BITS-1:0] c;
      a = CHAR_BITS'($urandom);
      b = CHAR_BITS'($urandom);
      c = CHAR_BITS'($urandom);
      case ($urandom_range(0, 3))
         0:       return a;
         1:       return a & b & c;
         2:       return a | b;
         default: return CHAR_BITS'(1 << $urandom_range(0, CHAR_BITS - 1));
      endcase
   endfunction

   initial begin : stimulus
      int phase;
      int n;
      logic [CFG_BITS-1:0] width_one;
      logic [CFG_BITS-1:0] width_two;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_character = '0;
      req_flush     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CFG_FIRST_CODE_BITS;
      csr_wdata     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset widths. The first flush finds an empty
      // packer and must produce nothing; later flushes carry a character that
      // must be ignored.
      offer_item(7'h55, 1'b1);
      offer_item(7'h00, 1'b0);
      offer_item(7'h7F, 1'b0);
      offer_item(7'h40, 1'b0);
      offer_item(7'h01, 1'b0);
      offer_item(7'h55, 1'b0);
      offer_item(7'h2A, 1'b0);
      offer_item(7'h7F, 1'b1);
      offer_item(7'h00, 1'b0);
      offer_item(7'h00, 1'b0);
      offer_item(7'h00, 1'b0);
      offer_item(7'h7F, 1'b0);
      offer_item(7'h10, 1'b0);
      offer_item(7'h00, 1'b1);
      offer_item(7'h2A, 1'b1);
      offer_item(7'h08, 1'b0);
      offer_item(7'h7F, 1'b0);
      offer_item(7'h03, 1'b0);
      offer_item(7'h60, 1'b0);
      offer_item(7'h00, 1'b1);

      // Each phase writes new widths and then sends random items. Phases end
      // on a zero character without a flush, so run counts survive into the
      // next setting; the order narrows each stage right after it was widest.
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       begin width_one = 3'd1; width_two = 3'd1; end
            1:       begin width_one = 3'd4; width_two = 3'd4; end
            2:       begin width_one = 3'd0; width_two = 3'd7; end
            3:       begin width_one = 3'd7; width_two = 3'd0; end
            4:       begin width_one = 3'd5; width_two = 3'd6; end
            5:       begin width_one = 3'd3; width_two = 3'd2; end
            6:       begin width_one = 3'd6; width_two = 3'd5; end
            default: begin
               width_one = CFG_BITS'($urandom_range(0, 7));
               width_two = CFG_BITS'($urandom_range(0, 7));
            end
         endcase
         req_burst <= (phase % 3 == 1);
         rsp_burst <= (phase % 3 == 2);
         write_widths(width_one, width_two);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE - 1)
               offer_item('0, 1'b0);
            else if ($urandom_range(0, 7) == 0)
               offer_item(CHAR_BITS'($urandom), 1'b1);
            else
               offer_item(random_char(), 1'b0);
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tzrc_pkg.sv
sv/tzrc_front.sv
sv/tzrc_back.sv
sv/two_stage_zero_run_compressor.sv
tb/tzrc_byte_checker.sv
tb/tb_two_stage_zero_run_compressor.sv
